// ===== rtl/ssio_pkg.sv =====
// Shared types, address codes and switch bit positions of the soft-switch register file.
package ssio_pkg;

    // Widths of the fields and of the stored state
    localparam int FLAG_W = 20;
    localparam int PAGE_W = 4;

    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [4:0]        flag_idx_t;

    // Access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Mode flag bit positions
    localparam flag_idx_t B_PAGE2  = 5'd10;
    localparam flag_idx_t B_AN3    = 5'd15;
    localparam flag_idx_t B_XRAM   = 5'd16;
    localparam flag_idx_t B_XWRITE = 5'd17;
    localparam flag_idx_t B_XBANK  = 5'd18;
    localparam flag_idx_t B_ZOOM   = 5'd19;

    // Video and annunciator switches start here
    localparam logic [1:0] VIDEO_BASE_HI = 2'b01;

    // Address groups by high nibble
    localparam logic [3:0] HI_MEM    = 4'h0;
    localparam logic [3:0] HI_STATUS = 4'h1;
    localparam logic [3:0] HI_VIDEO  = 4'h5;
    localparam logic [3:0] HI_EXP    = 4'h8;

    // Low nibbles with special meaning
    localparam logic [3:0] LO_NONE0    = 4'h0;
    localparam logic [3:0] LO_SETUP    = 4'h1;
    localparam logic [3:0] LO_NONE9    = 4'h9;
    localparam logic [3:0] LO_PAGE2CLR = 4'h1;

    // Single addresses
    localparam logic [7:0] ADDR_DHIRES   = 8'h7F;
    localparam logic [7:0] ADDR_PAGE_SEL = 8'h73;
    localparam logic [7:0] ADDR_BACKUP   = 8'h79;

    // Data codes
    localparam logic [7:0] BACKUP_RESTORE = 8'h5A;
    localparam logic [7:0] BACKUP_SAVE    = 8'hF1;
    localparam logic [7:0] DHIRES_OFF     = 8'hA0;

    localparam flags_t FLAGS_RESET = flags_t'(1) << B_ZOOM;

    // Request and result as carried between the stages
    typedef struct packed {
        logic       action;
        logic [7:0] io_address;
        logic [7:0] write_data;
        logic [7:0] key_latch;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       page_update;
        page_t      page_value;
    } result_t;

    // Memory switch selected by address bits 3:1
    function automatic flag_idx_t mem_ctl_bit(input logic [2:0] sel);
        flag_idx_t idx;
        unique case (sel)
            3'd0:    idx = 5'd0;
            3'd1:    idx = 5'd1;
            3'd2:    idx = 5'd2;
            3'd3:    idx = 5'd5;
            3'd4:    idx = 5'd3;
            3'd5:    idx = 5'd6;
            3'd6:    idx = 5'd4;
            default: idx = 5'd7;
        endcase
        return idx;
    endfunction

    // Status flag per low nibble; nibbles 0, 1 and 9 are decoded apart
    function automatic flag_idx_t status_bit(input logic [3:0] lo);
        flag_idx_t idx;
        unique case (lo)
            4'h2:    idx = 5'd16;
            4'h3:    idx = 5'd1;
            4'h4:    idx = 5'd2;
            4'h5:    idx = 5'd5;
            4'h6:    idx = 5'd3;
            4'h7:    idx = 5'd6;
            4'h8:    idx = 5'd0;
            4'hA:    idx = 5'd8;
            4'hB:    idx = 5'd9;
            4'hC:    idx = 5'd10;
            4'hD:    idx = 5'd11;
            4'hE:    idx = 5'd7;
            4'hF:    idx = 5'd4;
            default: idx = 5'd0;
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/soft_switch_io_register_file_unit.sv =====
// Top level of the soft-switch register file: input stage, state, result stage.
//
// One I/O access to the low byte of the soft-switch page enters per transfer on
// the s_ channel (tuser = direction, tdata = address, write data, keyboard byte).
// Every access gives exactly one result transfer on the m_ channel with the read
// byte, a decoded flag, a page update flag and the selected memory page.
// An accepted access is held in the input register, where the decoder updates
// the switch state and computes the result, which is then held in the output
// register that drives m_tvalid and the m_ channel data.
// Throughput: one access per clock while m_tready stays high; the switch state
// is updated in the same cycle the access is decoded, so the next access sees it at once.
// When m_tready is low, the result stays in the output register and one more
// access may wait in the input register; s_tready drops only when both are full.
// Reset (aresetn low at a clock edge) empties both registers, sets the mode flags
// to the zoom flag alone and clears the page and the saved copy.
module soft_switch_io_register_file_unit #(
    parameter int PAGE_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] io_address, [15:8] write_data, [23:16] key_latch
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [11:8] page_value, [15:12] zero
    output logic [1:0]  m_tuser    // [0] handled, [1] page_update
);

    logic                in_valid_reg;
    ssio_pkg::request_t  in_req_reg;
    logic                out_valid_reg;
    ssio_pkg::result_t   out_res_reg;

    ssio_pkg::flags_t    flags_reg;
    ssio_pkg::flags_t    flags_next;
    ssio_pkg::page_t     page_reg;
    ssio_pkg::page_t     page_next;
    ssio_pkg::flags_t    saved_flags_reg;
    ssio_pkg::flags_t    saved_flags_next;
    ssio_pkg::page_t     saved_page_reg;
    ssio_pkg::page_t     saved_page_next;
    ssio_pkg::result_t   res;

    logic                advance;
    logic                s_xfer;

    // Move the held access forward when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_req_reg.action     <= s_tuser[0];
            in_req_reg.io_address <= s_tdata[7:0];
            in_req_reg.write_data <= s_tdata[15:8];
            in_req_reg.key_latch  <= s_tdata[23:16];
        end
    end

    ssio_decode #(
        .PAGE_COUNT(PAGE_COUNT)
    ) u_decode (
        .req              (in_req_reg),
        .flags            (flags_reg),
        .page             (page_reg),
        .saved_flags      (saved_flags_reg),
        .saved_page       (saved_page_reg),
        .flags_next       (flags_next),
        .page_next        (page_next),
        .saved_flags_next (saved_flags_next),
        .saved_page_next  (saved_page_next),
        .res              (res)
    );

    // Commit switch state as each access is decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg       <= ssio_pkg::FLAGS_RESET;
            page_reg        <= '0;
            saved_flags_reg <= '0;
            saved_page_reg  <= '0;
        end else if (advance) begin
            flags_reg       <= flags_next;
            page_reg        <= page_next;
            saved_flags_reg <= saved_flags_next;
            saved_page_reg  <= saved_page_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.page_value, out_res_reg.read_data};
    assign m_tuser  = {out_res_reg.page_update, out_res_reg.handled};

endmodule

// ===== rtl/ssio_decode.sv =====
// Access decoder: next switch state and result for one registered access.
module ssio_decode #(
    parameter int PAGE_COUNT = 16
) (
    input  ssio_pkg::request_t req,
    input  ssio_pkg::flags_t   flags,
    input  ssio_pkg::page_t    page,
    input  ssio_pkg::flags_t   saved_flags,
    input  ssio_pkg::page_t    saved_page,
    output ssio_pkg::flags_t   flags_next,
    output ssio_pkg::page_t    page_next,
    output ssio_pkg::flags_t   saved_flags_next,
    output ssio_pkg::page_t    saved_page_next,
    output ssio_pkg::result_t  res
);

    // Page reduction table, built at elaboration
    ssio_pkg::page_t page_lut [256];

    genvar gi;
    generate
        for (gi = 0; gi < 256; gi++) begin : g_page_lut
            assign page_lut[gi] = ssio_pkg::page_t'(gi % PAGE_COUNT);
        end
    endgenerate

    logic [3:0] lo;
    logic [3:0] hi;
    logic       wr;
    logic       xw;
    logic       xr;
    logic       xb;
    logic [1:0] setup_code;

    assign lo = req.io_address[3:0];
    assign hi = req.io_address[7:4];
    assign wr = (req.action == ssio_pkg::ACT_WRITE);
    assign xw = flags[ssio_pkg::B_XWRITE];
    assign xr = flags[ssio_pkg::B_XRAM];
    assign xb = flags[ssio_pkg::B_XBANK];

    // Expansion setup code: write+ram 3, write 1, ram 0, neither 2
    always_comb begin
        priority if (xw && xr) begin
            setup_code = 2'd3;
        end else if (xw) begin
            setup_code = 2'd1;
        end else if (xr) begin
            setup_code = 2'd0;
        end else begin
            setup_code = 2'd2;
        end
    end

    // Decode the access in address priority order
    always_comb begin
        flags_next       = flags;
        page_next        = page;
        saved_flags_next = saved_flags;
        saved_page_next  = saved_page;
        res.read_data    = '0;
        res.handled      = 1'b0;
        res.page_update  = 1'b0;

        priority if (hi == ssio_pkg::HI_MEM && wr) begin
            res.handled = 1'b1;
            flags_next[ssio_pkg::mem_ctl_bit(lo[3:1])] = req.io_address[0];
            if (lo == ssio_pkg::LO_PAGE2CLR) begin
                flags_next[ssio_pkg::B_PAGE2] = 1'b0;
            end
        end else if (hi == ssio_pkg::HI_VIDEO) begin
            res.handled = 1'b1;
            flags_next[{ssio_pkg::VIDEO_BASE_HI, lo[3:1]}] = req.io_address[0];
        end else if (hi == ssio_pkg::HI_STATUS && !wr && lo != ssio_pkg::LO_NONE0
                     && lo != ssio_pkg::LO_NONE9) begin
            res.handled = 1'b1;
            if (lo == ssio_pkg::LO_SETUP) begin
                res.read_data = {xb, 3'b000, ~xb, 1'b0, setup_code} | req.key_latch;
            end else begin
                res.read_data = {flags[ssio_pkg::status_bit(lo)], 7'b0} | req.key_latch;
            end
        end else if (req.io_address == ssio_pkg::ADDR_DHIRES && !wr) begin
            res.handled   = 1'b1;
            res.read_data = flags[ssio_pkg::B_AN3] ? 8'h00 : ssio_pkg::DHIRES_OFF;
        end else if (req.io_address == ssio_pkg::ADDR_PAGE_SEL && wr) begin
            res.handled     = 1'b1;
            res.page_update = 1'b1;
            page_next       = page_lut[req.write_data];
        end else if (req.io_address == ssio_pkg::ADDR_BACKUP && wr) begin
            res.handled = 1'b1;
            if (req.write_data == ssio_pkg::BACKUP_RESTORE) begin
                flags_next      = saved_flags;
                page_next       = saved_page;
                res.page_update = 1'b1;
            end else if (req.write_data == ssio_pkg::BACKUP_SAVE) begin
                saved_flags_next = flags;
                saved_page_next  = page;
                res.page_update  = 1'b1;
            end
        end else if (hi == ssio_pkg::HI_EXP) begin
            res.handled = 1'b1;
            flags_next[ssio_pkg::B_XWRITE] = req.io_address[0];
            flags_next[ssio_pkg::B_XBANK]  = ~req.io_address[3];
            flags_next[ssio_pkg::B_XRAM]   = (req.io_address[1] == req.io_address[0]);
        end else begin
            // Leave an undecoded access unhandled with the state unchanged
            res.handled = 1'b0;
        end

        res.page_value = page_next;
    end

endmodule

// ===== test/tb_soft_switch_io_register_file_unit.sv =====
// Self-checking testbench for the soft-switch I/O register file: stimulus, predictor, checks.
`timescale 1ns / 1ps

module tb_soft_switch_io_register_file_unit;

    localparam int PAGE_COUNT      = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int VIDEO_FIRST_BIT = 8;
    localparam int NO_STATUS_FLAG  = -1;
    localparam int HOLD_CYCLES     = 40;

    // Predicts the soft-switch state and checks every result transfer in order
    class switch_scoreboard;
        ssio_pkg::flags_t  flags;
        ssio_pkg::page_t   page;
        ssio_pkg::flags_t  saved_flags;
        ssio_pkg::page_t   saved_page;
        ssio_pkg::result_t expected_results[$];
        int      mismatches;
        int      accesses;
        int      results_checked;
        int      saves;
        int      restores;
        int      page_writes;

        function new();
            flags       = ssio_pkg::FLAGS_RESET;
            page        = '0;
            saved_flags = '0;
            saved_page  = '0;
            mismatches  = 0;
        endfunction

        // Memory switch written by address bits 3:1
        function int mem_switch_bit(logic [2:0] sel);
            case (sel)
                3'd0: return 0;
                3'd1: return 1;
                3'd2: return 2;
                3'd3: return 5;
                3'd4: return 3;
                3'd5: return 6;
                3'd6: return 4;
                default: return 7;
            endcase
        endfunction

        // Flag reported in bit 7 of a status read
        function int status_flag_bit(logic [3:0] lo);
            case (lo)
                4'h2: return 16;
                4'h3: return 1;
                4'h4: return 2;
                4'h5: return 5;
                4'h6: return 3;
                4'h7: return 6;
                4'h8: return 0;
                4'hA: return 8;
                4'hB: return 9;
                4'hC: return 10;
                4'hD: return 11;
                4'hE: return 7;
                4'hF: return 4;
                default: return NO_STATUS_FLAG;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Advance the predicted state by one accepted access and queue its result
        function void note_access(ssio_pkg::request_t acc);
            ssio_pkg::result_t res;
            logic [3:0]  lo;
            logic [3:0]  hi;
            logic [7:0]  setup;
            logic        wr;
            logic [7:0]  a;
            res = '0;
            a   = acc.io_address;
            lo  = a[3:0];
            hi  = a[7:4];
            wr  = (acc.action == ssio_pkg::ACT_WRITE);
            accesses++;
            if (hi == ssio_pkg::HI_MEM && wr) begin
                res.handled = 1'b1;
                flags[mem_switch_bit(lo[3:1])] = a[0];
                if (lo == ssio_pkg::LO_PAGE2CLR) flags[ssio_pkg::B_PAGE2] = 1'b0;
            end else if (hi == ssio_pkg::HI_VIDEO) begin
                res.handled = 1'b1;
                flags[VIDEO_FIRST_BIT + int'(lo[3:1])] = a[0];
            end else if (hi == ssio_pkg::HI_STATUS && !wr && lo != ssio_pkg::LO_NONE0
                         && lo != ssio_pkg::LO_NONE9) begin
                res.handled = 1'b1;
                if (lo == ssio_pkg::LO_SETUP) begin
                    // Expansion setup code: write+ram 3, write 1, ram 0, neither 2
                    if (flags[ssio_pkg::B_XWRITE] && flags[ssio_pkg::B_XRAM]) setup = 8'h03;
                    else if (flags[ssio_pkg::B_XWRITE])                     setup = 8'h01;
                    else if (flags[ssio_pkg::B_XRAM])                       setup = 8'h00;
                    else                                                    setup = 8'h02;
                    if (!flags[ssio_pkg::B_XBANK]) setup = setup + 8'h08;
                    res.read_data = {flags[ssio_pkg::B_XBANK], 7'b0} | setup;
                end else begin
                    res.read_data = {flags[status_flag_bit(lo)], 7'b0};
                end
                res.read_data = res.read_data | acc.key_latch;
            end else if (a == ssio_pkg::ADDR_DHIRES && !wr) begin
                res.handled   = 1'b1;
                res.read_data = flags[ssio_pkg::B_AN3] ? 8'h00 : ssio_pkg::DHIRES_OFF;
            end else if (a == ssio_pkg::ADDR_PAGE_SEL && wr) begin
                res.handled     = 1'b1;
                page            = ssio_pkg::page_t'(int'(acc.write_data) % PAGE_COUNT);
                res.page_update = 1'b1;
                page_writes++;
            end else if (a == ssio_pkg::ADDR_BACKUP && wr) begin
                res.handled = 1'b1;
                if (acc.write_data == ssio_pkg::BACKUP_RESTORE) begin
                    flags           = saved_flags;
                    page            = saved_page;
                    res.page_update = 1'b1;
                    restores++;
                end else if (acc.write_data == ssio_pkg::BACKUP_SAVE) begin
                    saved_flags     = flags;
                    saved_page      = page;
                    res.page_update = 1'b1;
                    saves++;
                end
            end else if (hi == ssio_pkg::HI_EXP) begin
                res.handled               = 1'b1;
                flags[ssio_pkg::B_XWRITE] = a[0];
                flags[ssio_pkg::B_XBANK]  = ~a[3];
                flags[ssio_pkg::B_XRAM]   = (a[1] == a[0]);
            end
            res.page_value = page;
            expected_results.push_back(res);
        endfunction

        // Compare one result transfer with the oldest prediction
        task check_result(logic [15:0] data, logic [1:0] user);
            ssio_pkg::result_t want;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected, tdata %h tuser %b",
                                        data, user));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (data[7:0] !== want.read_data)
                    flag_mismatch($sformatf("read_data %h, expected %h",
                                            data[7:0], want.read_data));
                if (user[0] !== want.handled)
                    flag_mismatch($sformatf("handled %b, expected %b", user[0], want.handled));
                if (user[1] !== want.page_update)
                    flag_mismatch($sformatf("page_update %b, expected %b",
                                            user[1], want.page_update));
                if (data[11:8] !== want.page_value)
                    flag_mismatch($sformatf("page_value %h, expected %h",
                                            data[11:8], want.page_value));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] io_address, [15:8] write_data, [23:16] key_latch
    logic [0:0]  s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] read_data, [11:8] page_value, [15:12] zero
    logic [1:0]  m_tuser;   // [0] handled, [1] page_update

    switch_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycles;

    soft_switch_io_register_file_unit #(
        .PAGE_COUNT(PAGE_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic ssio_pkg::request_t make_access(logic act, logic [7:0] addr,
                                                       logic [7:0] wdata, logic [7:0] key);
        ssio_pkg::request_t acc;
        acc.action     = act;
        acc.io_address = addr;
        acc.write_data = wdata;
        acc.key_latch  = key;
        return acc;
    endfunction

    // Mostly decoded accesses in their proper direction, some wrong ones and noise
    function automatic ssio_pkg::request_t random_access();
        ssio_pkg::request_t acc;
        int       kind;
        kind           = $urandom_range(99);
        acc.write_data = 8'($urandom_range(255));
        acc.key_latch  = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
        acc.action     = 1'($urandom_range(1));
        if (kind < 20) begin
            acc.io_address = {ssio_pkg::HI_MEM, 4'($urandom_range(15))};
            acc.action     = ($urandom_range(9) == 0) ? ssio_pkg::ACT_READ
                                                      : ssio_pkg::ACT_WRITE;
        end else if (kind < 35) begin
            acc.io_address = {ssio_pkg::HI_VIDEO, 4'($urandom_range(15))};
        end else if (kind < 55) begin
            acc.io_address = {ssio_pkg::HI_STATUS, 4'($urandom_range(15))};
            acc.action     = ($urandom_range(9) == 0) ? ssio_pkg::ACT_WRITE
                                                      : ssio_pkg::ACT_READ;
        end else if (kind < 60) begin
            acc.io_address = ssio_pkg::ADDR_DHIRES;
            acc.action     = ($urandom_range(6) == 0) ? ssio_pkg::ACT_WRITE
                                                      : ssio_pkg::ACT_READ;
        end else if (kind < 68) begin
            acc.io_address = ssio_pkg::ADDR_PAGE_SEL;
            acc.action     = ($urandom_range(6) == 0) ? ssio_pkg::ACT_READ
                                                      : ssio_pkg::ACT_WRITE;
        end else if (kind < 76) begin
            acc.io_address = ssio_pkg::ADDR_BACKUP;
            acc.action     = ($urandom_range(9) == 0) ? ssio_pkg::ACT_READ
                                                      : ssio_pkg::ACT_WRITE;
            case ($urandom_range(4))
                0, 1:    acc.write_data = ssio_pkg::BACKUP_SAVE;
                2, 3:    acc.write_data = ssio_pkg::BACKUP_RESTORE;
                default: ;
            endcase
        end else if (kind < 88) begin
            acc.io_address = {ssio_pkg::HI_EXP, 4'($urandom_range(15))};
        end else begin
            acc.io_address = 8'($urandom_range(255));
        end
        return acc;
    endfunction

    // Offer one access until it is taken, then idle the bus cycle by cycle at idle_pct
    task automatic send_access(ssio_pkg::request_t acc);
        s_tvalid <= 1'b1;
        s_tdata  <= {acc.key_latch, acc.write_data, acc.io_address};
        s_tuser  <= acc.action;
        do @(posedge aclk); while (!s_tready);
        sb.note_access(acc);
        if (idle_pct > 0 && int'($urandom_range(99)) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (int'($urandom_range(99)) < idle_pct);
        end
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, with a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    // Check each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // End the run if it hangs
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ssio_pkg::ACT_READ;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset state, switch groups, page select, save and restore
        send_access(make_access(ssio_pkg::ACT_READ,  8'h11, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h7F, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h1F, 8'hFF, 8'hFF));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h55, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h1C, 8'h00, 8'h00));
        // Write at 01 sets 80STORE and also clears PAGE2
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h01, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h1C, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h18, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h0F, 8'hFF, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h5F, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h7F, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h5E, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h73, 8'hFF, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h79, ssio_pkg::BACKUP_SAVE, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h73, 8'h37, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h57, 8'h00, 8'h00));
        // Backup write with other data changes nothing
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h79, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h79, ssio_pkg::BACKUP_RESTORE,
                                8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h8B, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h11, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h80, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h11, 8'h00, 8'h01));
        // Undecoded: status reads at 10 and 19, wrong directions, unused address
        send_access(make_access(ssio_pkg::ACT_READ,  8'h10, 8'h00, 8'hFF));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h19, 8'h00, 8'hFF));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h1A, 8'hFF, 8'hFF));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h05, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h7F, 8'h00, 8'h00));
        send_access(make_access(ssio_pkg::ACT_READ,  8'h73, 8'hFF, 8'h00));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'hFF, 8'hFF, 8'hFF));
        send_access(make_access(ssio_pkg::ACT_WRITE, 8'h73, 8'h00, 8'h00));
        drain();

        // Back-pressure: hold the receiver off while accesses keep coming
        hold_left = HOLD_CYCLES;
        repeat (12) send_access(random_access());
        drain();

        // Random phases with different idle and stall rates
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            repeat (ITEMS_PER_PHASE) send_access(random_access());
            drain();
        end
        stall_pct = 0;
        repeat (8) @(posedge aclk);

        $display("covered %0d accesses, %0d results checked", sb.accesses, sb.results_checked);
        $display("page writes %0d, saves %0d, restores %0d, mismatches %0d",
                 sb.page_writes, sb.saves, sb.restores, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ssio_pkg.sv
rtl/ssio_decode.sv
rtl/soft_switch_io_register_file_unit.sv
test/tb_soft_switch_io_register_file_unit.sv
